>>> src/slk_pkg.sv
// slk_pkg: shared types, constants and sequencer states for the
// single-linkage k-clustering block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slk_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 10;
  localparam int unsigned CountW       = 9;
  localparam int unsigned SqW          = 25;
  localparam int unsigned DistW        = 23;

  localparam logic [CountW-1:0] CountReset = 9'd2;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_RUN  = 1'b1
  } req_type_e;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_BAD_CNT = 1'b1
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic signed [11:0] point_x;
    logic signed [11:0] point_y;
  } slk_in_t;

  typedef struct packed {
    logic [SqW-1:0]   squared_distance;
    logic [DistW-1:0] distance_fixed;
    logic             status;
  } slk_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_SCAN_RD,
    S_SCAN_WR,
    S_PICK,
    S_SEL_RD,
    S_SEL_CHK,
    S_SQRT,
    S_OUT
  } slk_state_e;

endpackage
`default_nettype wire

>>> src/slk_ram.sv
// slk_ram: generic single-port-write, single-port-read RAM with
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module slk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> src/slk_sqrt.sv
// slk_sqrt: bit-serial fixed-point square root, one result bit per cycle.
// Depends on slk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slk_sqrt
  import slk_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SqW-1:0]   value_i,
  output      logic             done_o,
  output      logic [DistW-1:0] root_o
);

  localparam int unsigned Steps = (SqW + 1) / 2 + FracBits;
  localparam int unsigned StepW = $clog2(Steps + 1);
  localparam int unsigned RadW  = 2 * Steps;
  localparam int unsigned RootW = Steps;
  localparam int unsigned RemW  = RootW + 2;

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [RemW-1:0]  rem_sh, trial;

  // one digit step: shift in two radicand bits, try subtract
  always_comb begin
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1:RadW-2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = RadW'({value_i, (2 * FracBits)'(0)});
      root_d = '0;
      rem_d  = '0;
      cnt_d  = StepW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == StepW'(1));
  assign root_o = DistW'(root_d);

endmodule
`default_nettype wire

>>> src/single_linkage_k_clustering.sv
// single_linkage_k_clustering: top level, sequencer and distance unit.
// Depends on slk_pkg, slk_ram, slk_sqrt.
//
// Usage: input words (req_type, point_x, point_y) arrive on in_valid_i /
// in_stall_o. A load word stores one point; loads past MaxPoints are
// dropped. A run word computes a Prim spanning tree over the n loaded
// points with one shared squared-distance unit, then selects the
// (n-k)-th smallest tree edge by counting, and finally takes a
// bit-serial square root. One result word leaves on out_valid_o /
// out_stall_i per run; the run clears the point set.
// Run time is set by the single distance unit and the one read port of
// each memory. A bad cluster count skips the tree and goes straight to
// the output state; its result has status 1. The input is stalled for
// the whole run; a finished result waits in the output register under
// out_stall_i and holds its value, while loads are still taken. Reset
// clears the point count, sets cluster count to 2 and empties the
// output register. Memories need no clearing. cfg_valid_i/cfg_ready_o
// writes cluster_count while idle with no result waiting.
`timescale 1ns / 1ps
`default_nettype none
module single_linkage_k_clustering
  import slk_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire slk_in_t           in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      slk_out_t          out_data_o,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned NW = $clog2(MaxPoints + 1);
  localparam int unsigned DW = 2 * CoordBits + 2;

  slk_state_e state_q, state_d;
  logic [CountW-1:0] k_q;
  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d, pick_q, pick_d;
  logic [NW-1:0] step_q, step_d, rank_q, rank_d;
  logic          found_q, found_d;
  logic [DW-1:0] best_q, best_d, cand_q, cand_d, ans_q, ans_d;
  logic [AW:0]   cntlt_q, cntlt_d, cntle_q, cntle_d;
  logic          out_v_q;
  slk_out_t      out_q;
  logic [MaxPoints-1:0] in_tree_q, in_tree_d;
  logic [DistW-1:0] sq_root_q;
  logic             status_bad_q;
  logic             out_free;

  // point memories, best-length memory and a separate tree-edge memory
  logic              pt_we, bl_we;
  logic [AW-1:0]     pt_wa, pt_ra, bl_wa, bl_ra, te_wa, te_ra;
  logic [CoordBits-1:0] x_rd, y_rd, px_q, py_q;
  logic [DW-1:0]     bl_wd, bl_rd, te_rd;
  logic              te_we;
  logic signed [CoordBits-1:0] ld_x, ld_y;

  assign ld_x = in_data_i.point_x[CoordBits-1:0];
  assign ld_y = in_data_i.point_y[CoordBits-1:0];

  slk_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_xs (
    .clk_i, .we_i(pt_we), .waddr_i(pt_wa), .wdata_i(ld_x),
    .raddr_i(pt_ra), .rdata_o(x_rd));
  slk_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_ys (
    .clk_i, .we_i(pt_we), .waddr_i(pt_wa), .wdata_i(ld_y),
    .raddr_i(pt_ra), .rdata_o(y_rd));
  slk_ram #(.Width(DW), .Depth(MaxPoints)) u_best (
    .clk_i, .we_i(bl_we), .waddr_i(bl_wa), .wdata_i(bl_wd),
    .raddr_i(bl_ra), .rdata_o(bl_rd));
  slk_ram #(.Width(DW), .Depth(MaxPoints)) u_edges (
    .clk_i, .we_i(te_we), .waddr_i(te_wa), .wdata_i(best_q),
    .raddr_i(te_ra), .rdata_o(te_rd));

  // shared squared-distance unit against the reference point
  logic signed [CoordBits:0] dx, dy;
  logic [DW-1:0] pair_len;
  assign dx   = $signed({x_rd[CoordBits-1], x_rd}) - $signed({px_q[CoordBits-1], px_q});
  assign dy   = $signed({y_rd[CoordBits-1], y_rd}) - $signed({py_q[CoordBits-1], py_q});
  assign pair_len = DW'(dx * dx) + DW'(dy * dy);

  logic in_acc, run_acc, load_acc, k_bad;
  logic sq_start, sq_done;
  logic [DistW-1:0] sq_root;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign load_acc    = in_acc && (in_data_i.req_type == REQ_LOAD);
  assign run_acc     = in_acc && (in_data_i.req_type == REQ_RUN);
  assign k_bad       = (k_q < CountW'(2)) || (32'(k_q) > 32'(n_q));
  assign cfg_ready_o = (state_q == S_IDLE) && !out_v_q;
  assign pt_we       = load_acc && (n_q < NW'(MaxPoints));
  assign pt_wa       = n_q[AW-1:0];
  assign out_free    = !out_v_q || !out_stall_i;

  slk_sqrt #(.FracBits(FracBits)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .value_i(SqW'(ans_q)),
    .done_o(sq_done), .root_o(sq_root));

  // sequencer: Prim build, then rank select by counting, then root
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = j_q;
    pick_d    = pick_q;
    step_d    = step_q;
    rank_d    = rank_q;
    found_d   = found_q;
    best_d    = best_q;
    cand_d    = cand_q;
    ans_d     = ans_q;
    cntlt_d   = cntlt_q;
    cntle_d   = cntle_q;
    in_tree_d = in_tree_q;
    pt_ra     = i_q;
    bl_we     = 1'b0;
    bl_wa     = i_q;
    bl_wd     = pair_len;
    bl_ra     = i_q;
    te_we     = 1'b0;
    te_wa     = step_q[AW-1:0];
    te_ra     = i_q;
    sq_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (pt_we) begin
          n_d = n_q + 1'b1;
        end
        pt_ra = '0;
        if (run_acc) begin
          if (k_bad) begin
            ans_d   = '0;
            state_d = S_OUT;
            n_d     = '0;
          end else begin
            in_tree_d    = '0;
            in_tree_d[0] = 1'b1;
            pick_d  = '0;
            i_d     = '0;
            step_d  = NW'(1);
            state_d = S_INIT_RD;
          end
        end
      end
      // fetch reference point (pick), then sweep best lengths
      S_INIT_RD: begin
        pt_ra   = pick_q;
        i_d     = '0;
        state_d = S_SCAN_RD;
        found_d = 1'b0;
      end
      S_SCAN_RD: begin
        pt_ra   = i_q;
        bl_ra   = i_q;
        state_d = S_SCAN_WR;
      end
      S_SCAN_WR: begin
        // update best[i] with distance to pick and track minimum
        if (!in_tree_q[i_q]) begin
          if ((step_q == NW'(1)) || (pair_len < bl_rd)) begin
            bl_we = 1'b1;
            bl_wd = pair_len;
            cand_d = pair_len;
          end else begin
            cand_d = bl_rd;
          end
          if (!found_q || (cand_d < best_q)) begin
            best_d  = cand_d;
            j_d     = i_q;
            found_d = 1'b1;
          end
        end
        if (NW'(i_q) + 1'b1 == n_q) begin
          state_d = S_PICK;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_PICK: begin
        // new reference point is read here, latched in the next state
        pt_ra  = j_q;
        te_we  = 1'b1;
        te_wa  = AW'(step_q - 1'b1);
        in_tree_d[j_q] = 1'b1;
        pick_d = j_q;
        if (step_q + 1'b1 == n_q) begin
          rank_d  = n_q - NW'(k_q);
          i_d     = '0;
          state_d = S_SEL_RD;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_INIT_RD;
        end
      end
      // candidate i: count edges below and at-or-below its value
      S_SEL_RD: begin
        te_ra   = i_q;
        j_d     = '0;
        cntlt_d = '0;
        cntle_d = '0;
        state_d = S_SEL_CHK;
        found_d = 1'b0;
      end
      S_SEL_CHK: begin
        if (!found_q) begin
          cand_d  = te_rd;
          found_d = 1'b1;
        end else begin
          if (te_rd < cand_q) cntlt_d = cntlt_q + 1'b1;
          if (te_rd <= cand_q) cntle_d = cntle_q + 1'b1;
          if (NW'(j_q) + 2'd2 == n_q) begin
            if ((NW'(cntlt_d) <= rank_q) && (NW'(cntle_d) > rank_q)) begin
              ans_d    = cand_q;
              found_d  = 1'b0;
              state_d  = S_SQRT;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = S_SEL_RD;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
        // the edge compared next cycle
        te_ra = j_d;
      end
      S_SQRT: begin
        if (!found_q) begin
          sq_start = 1'b1;
          found_d  = 1'b1;
        end else if (sq_done) begin
          n_d     = '0;
          state_d = S_OUT;
        end
      end
      // wait here until the output register is free
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the comparison loop reads te at j; the first cycle loads candidate
  // from te at i, so te_ra follows j only after the first read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= '0;
      k_q       <= CountReset;
      out_v_q   <= 1'b0;
      in_tree_q <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      in_tree_q <= in_tree_d;
      found_q   <= (state_q == S_PICK) ? 1'b0 : found_d;
      if (cfg_valid_i && cfg_ready_o) begin
        k_q <= cfg_data_i;
      end
      if ((state_q == S_OUT) && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // datapath registers; reference point latched after its read
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    pick_q <= pick_d;
    step_q <= step_d;
    rank_q <= rank_d;
    best_q <= best_d;
    cand_q <= cand_d;
    ans_q  <= ans_d;
    cntlt_q <= cntlt_d;
    cntle_q <= cntle_d;
    if (state_q == S_INIT_RD) begin
      px_q <= x_rd;
      py_q <= y_rd;
    end
    if ((state_q == S_OUT) && out_free) begin
      out_q.squared_distance <= SqW'(ans_q);
      out_q.distance_fixed   <= (ans_q == '0) ? '0 : sq_root_q;
      out_q.status           <= (ans_q == '0 && status_bad_q) ? ST_BAD_CNT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_done) sq_root_q <= sq_root;
    if (run_acc) status_bad_q <= k_bad;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");
  // a run always clears the point count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> (n_q == '0)) else $error("point set not cleared");
  // configuration only while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> (state_q == S_IDLE)) else $error("config while busy");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// testbench: self-checking bench for single_linkage_k_clustering.
// Depends on slk_pkg and the block's RTL; predicts each run result in place.
`timescale 1ns / 1ps
module testbench;
  import slk_pkg::*;

  localparam int unsigned NPts     = 256;
  localparam int unsigned TbLimit  = 2000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  slk_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  slk_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CountW-1:0] cfg_data_i = '0;

  single_linkage_k_clustering dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic signed [11:0] pt_x[NPts];
  logic signed [11:0] pt_y[NPts];
  int unsigned        pt_count;
  logic [CountW-1:0]  k_wanted;
  slk_out_t           expected_q[$];

  int unsigned errors, runs_seen, loads_sent, bad_seen;
  int          send_idle_pct, recv_idle_pct;
  int unsigned quiet_cycles;

  function automatic longint unsigned pair_sq(int a, int b);
    longint dx, dy;
    dx = longint'(pt_x[a]) - longint'(pt_x[b]);
    dy = longint'(pt_y[a]) - longint'(pt_y[b]);
    return longint'(dx * dx + dy * dy);
  endfunction

  // floor(sqrt(d) * 2^10), digit by digit
  function automatic longint unsigned root_fixed(longint unsigned d);
    longint unsigned root, rem, pair, trial;
    root = 0;
    rem = 0;
    for (int i = 31 + FracBitsDef; i >= 0; i--) begin
      pair = (i >= FracBitsDef) ? ((d >> (2 * (i - FracBitsDef))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // spanning tree, then the (n-k)-th smallest edge
  function automatic slk_out_t cluster_gap();
    longint unsigned near_len[NPts];
    bit              joined[NPts];
    longint unsigned edge_len[$];
    slk_out_t        r;
    int              n, pick;
    longint unsigned d;
    n = pt_count;
    r = '0;
    if (k_wanted < 2 || k_wanted > n) begin
      r.status = ST_BAD_CNT;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      joined[i] = 1'b0;
      near_len[i] = pair_sq(0, i);
    end
    joined[0] = 1'b1;
    for (int s = 1; s < n; s++) begin
      pick = -1;
      for (int i = 0; i < n; i++)
        if (!joined[i] && (pick < 0 || near_len[i] < near_len[pick])) pick = i;
      joined[pick] = 1'b1;
      edge_len = {edge_len, near_len[pick]};
      for (int i = 0; i < n; i++)
        if (!joined[i]) begin
          d = pair_sq(pick, i);
          if (d < near_len[i]) near_len[i] = d;
        end
    end
    edge_len.sort();
    d = edge_len[n - k_wanted];
    r.squared_distance = d[SqW-1:0];
    r.distance_fixed = DistW'(root_fixed(d));
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch run %0d: %s got %0d want %0d", runs_seen, what, got, want);
    errors++;
  endtask

  // drop the input valid once no further word follows
  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  // send one word, predict on acceptance
  task automatic send_word(req_type_e rt, int x, int y);
    while (($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{req_type: rt, point_x: 12'(x), point_y: 12'(y)};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (rt == REQ_LOAD) begin
      loads_sent++;
      if (pt_count < NPts) begin
        pt_x[pt_count] = 12'(x);
        pt_y[pt_count] = 12'(y);
        pt_count++;
      end
    end else begin
      expected_q = {expected_q, cluster_gap()};
      pt_count = 0;
    end
  endtask

  task automatic drain();
    release_input();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_k(int k);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CountW'(k);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    k_wanted = CountW'(k);
  endtask

  task automatic run_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_word(REQ_LOAD, $urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
    send_word(REQ_RUN, $urandom, $urandom);
  endtask

  // directed: extreme coordinates, ties, bad counts
  task automatic test_directed();
    send_word(REQ_RUN, 0, 0);                 // empty set, default k
    send_word(REQ_LOAD, -2048, -2048);
    send_word(REQ_LOAD, 2047, 2047);
    send_word(REQ_RUN, 0, 0);                 // farthest pair
    send_word(REQ_LOAD, -2048, 2047);
    send_word(REQ_LOAD, 2047, -2048);
    send_word(REQ_LOAD, 0, 0);
    send_word(REQ_LOAD, 0, 0);                // duplicate point
    send_word(REQ_RUN, 0, 0);
    send_word(REQ_LOAD, 1, 0);
    send_word(REQ_RUN, 0, 0);                 // k above count
    drain();
    set_k(1);
    send_word(REQ_LOAD, 3, 4);
    send_word(REQ_LOAD, 0, 0);
    send_word(REQ_RUN, 0, 0);                 // k below two
    drain();
    set_k(3);
    send_word(REQ_LOAD, 0, 0);
    send_word(REQ_LOAD, 1, 0);
    send_word(REQ_LOAD, 0, 1);
    send_word(REQ_LOAD, 5, 5);
    send_word(REQ_RUN, 0, 0);                 // equal distances
    drain();
  endtask

  // full store with overflow loads, k at its top
  task automatic test_full_store();
    set_k(NPts);
    for (int i = 0; i < NPts + 3; i++)
      send_word(REQ_LOAD, $urandom_range(4095) - 2048, $urandom_range(4095) - 2048);
    send_word(REQ_RUN, 0, 0);
    drain();
    set_k(511);
    run_set(4, 2047);
    drain();
  endtask

  // random sets, mostly small; k varies per phase
  task automatic test_random(int words);
    int sent, n, span;
    sent = 0;
    while (sent < words) begin
      set_k($urandom_range(9) < 8 ? $urandom_range(2, 8) : $urandom_range(0, 20));
      for (int j = 0; j < 6; j++) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
        span = ($urandom_range(1)) ? 2047 : $urandom_range(1, 20);
        run_set(n, span);
        sent += n + 1;
      end
      drain();
    end
  endtask

  // receiver stall and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        runs_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          slk_out_t w;
          w = expected_q.pop_front();
          if (w.status == ST_BAD_CNT) bad_seen++;
          if (out_data_o.squared_distance !== w.squared_distance)
            report_mismatch("squared_distance", out_data_o.squared_distance,
                            w.squared_distance);
          if (out_data_o.distance_fixed !== w.distance_fixed)
            report_mismatch("distance_fixed", out_data_o.distance_fixed, w.distance_fixed);
          if (out_data_o.status !== w.status)
            report_mismatch("status", out_data_o.status, w.status);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= TbLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    quiet_cycles = 0;
    errors = 0;
    runs_seen = 0;
    loads_sent = 0;
    bad_seen = 0;
    pt_count = 0;
    k_wanted = CountReset;
    send_idle_pct = 26;
    recv_idle_pct = 46;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    test_random(250);
    send_idle_pct = 46;
    recv_idle_pct = 26;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    drain();
    $display("covered %0d point loads and %0d cluster runs (%0d with bad count)",
             loads_sent, runs_seen, bad_seen);
    if (errors == 0 && expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
